[src/erxf_pkg.sv]
// ----------------------------------------------------------------------------
// Receive address filter package
// Widths, codes, register indexes and shared types of the receive address
// filter and EtherType demultiplexer.
// ----------------------------------------------------------------------------
package erxf_pkg;

	// Field widths.
	localparam int MAC_W       = 48;
	localparam int TYPE_W      = 16;
	localparam int LEN_W       = 11;
	localparam int CNT_W       = 32;
	localparam int BYTE_CNT_W  = 48;
	localparam int SLOT_W      = 4;
	localparam int VERDICT_W   = 3;
	localparam int CLASS_W     = 2;
	localparam int TCOUNT_W    = 5;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 64;

	// EtherType slots packed into one 64-bit table register.
	localparam int SLOTS_PER_WORD = 4;

	// Frame geometry.
	localparam logic [LEN_W-1:0] HEADER_BYTES    = 11'd14;
	localparam logic [LEN_W-1:0] MIN_FRAME_BYTES = 11'd60;
	localparam logic [LEN_W-1:0] MAX_FRAME_BYTES = 11'd1514;

	// Type values below this are a length field.
	localparam logic [TYPE_W-1:0] LEN_TYPE_LIMIT = 16'h0600;

	// Group bit: bit 0 of the first octet.
	localparam int GROUP_BIT_POS = MAC_W - 8;

	// Depth of the queue between classifier and counter stage.
	localparam int QUEUE_DEPTH = 2;

	// Verdict codes.
	localparam logic [VERDICT_W-1:0] VERDICT_DELIVERED  = 3'd0;
	localparam logic [VERDICT_W-1:0] VERDICT_RUNT       = 3'd1;
	localparam logic [VERDICT_W-1:0] VERDICT_INVALID    = 3'd2;
	localparam logic [VERDICT_W-1:0] VERDICT_NOT_ADDR   = 3'd3;
	localparam logic [VERDICT_W-1:0] VERDICT_NO_HANDLER = 3'd4;

	// Address class codes.
	localparam logic [CLASS_W-1:0] CLASS_NONE    = 2'd0;
	localparam logic [CLASS_W-1:0] CLASS_BCAST   = 2'd1;
	localparam logic [CLASS_W-1:0] CLASS_MCAST   = 2'd2;
	localparam logic [CLASS_W-1:0] CLASS_UCAST   = 2'd3;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_STATION    = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_PROMISC    = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_TYPE_COUNT = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_TYPE_A     = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_TYPE_B     = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_TYPE_C     = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_TYPE_D     = 3'd6;

	// Filter settings seen by the classifier.
	typedef struct packed {
		logic [MAC_W-1:0]    station_addr;
		logic                promiscuous;
		logic [TCOUNT_W-1:0] type_count;
	} filt_cfg_t;

	// One classified frame as it waits for the counter stage.
	typedef struct packed {
		logic [VERDICT_W-1:0] verdict;
		logic [SLOT_W-1:0]    slot;
		logic [CLASS_W-1:0]   addr_class;
		logic [LEN_W-1:0]     frame_bytes;
	} cls_item_t;

	// Saturating increment of a 32-bit counter.
	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (&v) ? v : v + CNT_W'(1);
	endfunction

endpackage

[src/erxf_front.sv]
// ----------------------------------------------------------------------------
// Receive address filter classifier
// Validates one frame header summary, classes its destination address and
// looks its type up first-hit in the EtherType table.
// ----------------------------------------------------------------------------
module erxf_front import erxf_pkg::*; #(
	parameter int TYPE_SLOTS = 16
) (
	input  logic [MAC_W-1:0]  dest_mac,
	input  logic [MAC_W-1:0]  src_mac,
	input  logic [TYPE_W-1:0] type_field,
	input  logic [LEN_W-1:0]  frame_bytes,
	input  filt_cfg_t         cfg,
	input  logic [TYPE_W-1:0] type_tab [TYPE_SLOTS],
	output cls_item_t         item
);

	logic                  is_runt;
	logic                  is_invalid;
	logic                  is_bcast;
	logic                  is_mcast;
	logic                  is_dropped;
	logic [LEN_W-1:0]      body_len;
	logic [TYPE_SLOTS-1:0] hit;
	logic                  found;
	logic [SLOT_W-1:0]     found_slot;

	// Length and address validation.
	always_comb begin
		body_len    = frame_bytes - HEADER_BYTES;
		is_runt     = frame_bytes < HEADER_BYTES;
		is_invalid  = (frame_bytes < MIN_FRAME_BYTES) || (frame_bytes > MAX_FRAME_BYTES) ||
			(dest_mac == '0) || (src_mac == '0) ||
			((type_field < LEN_TYPE_LIMIT) &&
			(type_field != {{(TYPE_W-LEN_W){1'b0}}, body_len}));
	end

	// Destination address class and station match.
	always_comb begin
		is_bcast   = &dest_mac;
		is_mcast   = !is_bcast && dest_mac[GROUP_BIT_POS];
		is_dropped = !is_bcast && !is_mcast &&
			(dest_mac != cfg.station_addr) && !cfg.promiscuous;
	end

	// Parallel compare against the enabled table slots.
	always_comb begin
		for (int i = 0; i < TYPE_SLOTS; i++) begin
			hit[i] = (TCOUNT_W'(i) < cfg.type_count) && (type_tab[i] == type_field);
		end
	end

	// Lowest matching slot wins.
	always_comb begin
		found      = 1'b0;
		found_slot = '0;
		for (int i = TYPE_SLOTS - 1; i >= 0; i--) begin
			if (hit[i]) begin
				found      = 1'b1;
				found_slot = SLOT_W'(i);
			end
		end
	end

	// Assemble the classified item.
	always_comb begin
		item.frame_bytes = frame_bytes;
		item.slot        = '0;
		item.addr_class  = CLASS_NONE;
		if (is_runt) begin
			item.verdict = VERDICT_RUNT;
		end else if (is_invalid) begin
			item.verdict = VERDICT_INVALID;
		end else begin
			if (is_bcast) begin
				item.addr_class = CLASS_BCAST;
			end else if (is_mcast) begin
				item.addr_class = CLASS_MCAST;
			end else begin
				item.addr_class = CLASS_UCAST;
			end
			if (is_dropped) begin
				item.verdict = VERDICT_NOT_ADDR;
			end else if (found) begin
				item.verdict = VERDICT_DELIVERED;
				item.slot    = found_slot;
			end else begin
				item.verdict = VERDICT_NO_HANDLER;
			end
		end
	end

endmodule

[src/erxf_queue.sv]
// ----------------------------------------------------------------------------
// Receive address filter queue
// Short first-in first-out buffer of classified frames between the
// classifier and the counter stage.
// ----------------------------------------------------------------------------
module erxf_queue import erxf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  cls_item_t push_item,
	output logic      full,
	input  logic      pop,
	output cls_item_t pop_item,
	output logic      not_empty
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(QUEUE_DEPTH);

	cls_item_t        entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [OCC_W-1:0] occ_q;

	assign full      = occ_q == FULL_OCC;
	assign not_empty = occ_q != '0;
	assign pop_item  = entry_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	// Pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			occ_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				occ_q <= occ_q + OCC_W'(1);
			end else if (pop && !push) begin
				occ_q <= occ_q - OCC_W'(1);
			end
		end
	end

endmodule

[src/erxf_back.sv]
// ----------------------------------------------------------------------------
// Receive address filter counter stage
// Takes classified frames from the queue, advances the saturating
// statistics counters and holds the result in the output register.
// ----------------------------------------------------------------------------
module erxf_back import erxf_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	input  cls_item_t             item,
	output logic                  item_take,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [VERDICT_W-1:0]  verdict,
	output logic [SLOT_W-1:0]     handler_slot,
	output logic [CLASS_W-1:0]    addr_class,
	output logic [CNT_W-1:0]      rx_frames,
	output logic [BYTE_CNT_W-1:0] rx_bytes,
	output logic [CNT_W-1:0]      bcast_frames,
	output logic [CNT_W-1:0]      mcast_frames,
	output logic [CNT_W-1:0]      ucast_frames,
	output logic [CNT_W-1:0]      filtered_frames,
	output logic [CNT_W-1:0]      length_errors
);

	logic                  out_valid_q;
	logic [VERDICT_W-1:0]  verdict_q;
	logic [SLOT_W-1:0]     slot_q;
	logic [CLASS_W-1:0]    class_q;
	logic [CNT_W-1:0]      rx_frames_q;
	logic [BYTE_CNT_W-1:0] rx_bytes_q;
	logic [CNT_W-1:0]      bcast_q;
	logic [CNT_W-1:0]      mcast_q;
	logic [CNT_W-1:0]      ucast_q;
	logic [CNT_W-1:0]      dropped_q;
	logic [CNT_W-1:0]      len_err_q;
	logic                  good_frame;
	logic [BYTE_CNT_W:0]   bytes_sum;
	logic [BYTE_CNT_W-1:0] bytes_next;

	// A new item moves in when the output register is free or being drained.
	assign item_take = item_valid && (!out_valid_q || out_ready);

	// Which counters this frame moves.
	always_comb begin
		good_frame = item.verdict inside {VERDICT_DELIVERED, VERDICT_NOT_ADDR,
			VERDICT_NO_HANDLER};
	end

	// Saturating byte count.
	always_comb begin
		bytes_sum  = {1'b0, rx_bytes_q} + (BYTE_CNT_W+1)'(item.frame_bytes);
		bytes_next = bytes_sum[BYTE_CNT_W] ? '1 : bytes_sum[BYTE_CNT_W-1:0];
	end

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (item_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Per-frame result fields.
	always_ff @(posedge clk) begin
		if (item_take) begin
			verdict_q <= item.verdict;
			slot_q    <= item.slot;
			class_q   <= item.addr_class;
		end
	end

	// Statistics counters; they only move when a result enters the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_frames_q <= '0;
			rx_bytes_q  <= '0;
			bcast_q     <= '0;
			mcast_q     <= '0;
			ucast_q     <= '0;
			dropped_q   <= '0;
			len_err_q   <= '0;
		end else if (item_take) begin
			if (item.verdict == VERDICT_INVALID) begin
				len_err_q <= sat_inc(len_err_q);
			end
			if (good_frame) begin
				rx_frames_q <= sat_inc(rx_frames_q);
				rx_bytes_q  <= bytes_next;
				case (item.addr_class)
					CLASS_BCAST: bcast_q <= sat_inc(bcast_q);
					CLASS_MCAST: mcast_q <= sat_inc(mcast_q);
					CLASS_UCAST: ucast_q <= sat_inc(ucast_q);
					default: ;
				endcase
			end
			if (item.verdict == VERDICT_NOT_ADDR) begin
				dropped_q <= sat_inc(dropped_q);
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign verdict         = verdict_q;
	assign handler_slot    = slot_q;
	assign addr_class      = class_q;
	assign rx_frames       = rx_frames_q;
	assign rx_bytes        = rx_bytes_q;
	assign bcast_frames    = bcast_q;
	assign mcast_frames    = mcast_q;
	assign ucast_frames    = ucast_q;
	assign filtered_frames = dropped_q;
	assign length_errors   = len_err_q;

endmodule

[src/eth_rx_address_filter_demux_core.sv]
// ----------------------------------------------------------------------------
// Ethernet receive address filter and EtherType demultiplexer
// Top level: configuration registers, classifier, queue and counter stage.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid / in_ready) carries one header summary per
// received frame: addresses, type field and total length. The output channel
// (out_valid / out_ready) returns one result per frame: verdict, matched
// table slot, address class and the statistics counters after that frame.
// A transfer on the input is classified in the same cycle and written to a
// two-entry queue; the counter stage then takes it from the queue when the
// output register is free or being drained, updates the counters and loads
// the output register, from which out_valid is driven. One frame per cycle
// is sustained while out_ready is high; the rate is set by the single
// counter update per cycle.
// When the receiver stalls, the result holds in the output register and the
// queue keeps taking frames until it is full, then in_ready falls.
// The configuration port writes a register when cfg_we is high; a write to
// an index beyond the list is ignored. The user must make writes only while
// idle; the block does not enforce this. Reset clears all configuration
// registers, the EtherType table and the counters; no clearing pass is needed.
// ----------------------------------------------------------------------------
module eth_rx_address_filter_demux_core import erxf_pkg::*; #(
	parameter int TYPE_SLOTS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [MAC_W-1:0]       dest_mac,
	input  logic [MAC_W-1:0]       src_mac,
	input  logic [TYPE_W-1:0]      type_field,
	input  logic [LEN_W-1:0]       frame_bytes,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [VERDICT_W-1:0]   verdict,
	output logic [SLOT_W-1:0]      handler_slot,
	output logic [CLASS_W-1:0]     addr_class,
	output logic [CNT_W-1:0]       rx_frames,
	output logic [BYTE_CNT_W-1:0]  rx_bytes,
	output logic [CNT_W-1:0]       bcast_frames,
	output logic [CNT_W-1:0]       mcast_frames,
	output logic [CNT_W-1:0]       ucast_frames,
	output logic [CNT_W-1:0]       filtered_frames,
	output logic [CNT_W-1:0]       length_errors
);

	filt_cfg_t         cfg_q;
	logic [TYPE_W-1:0] type_tab_q [TYPE_SLOTS];
	cls_item_t         front_item;
	cls_item_t         queue_item;
	logic              queue_full;
	logic              queue_valid;
	logic              queue_pop;
	logic              push;

	// Scalar configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_STATION:    cfg_q.station_addr <= cfg_data[MAC_W-1:0];
				REG_PROMISC:    cfg_q.promiscuous  <= cfg_data[0];
				REG_TYPE_COUNT: cfg_q.type_count   <= cfg_data[TCOUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// EtherType table: each 64-bit table register holds four slots.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < TYPE_SLOTS; s++) begin
				type_tab_q[s] <= '0;
			end
		end else if (cfg_we) begin
			for (int s = 0; s < TYPE_SLOTS; s++) begin
				if (cfg_index == REG_TYPE_A + CFG_INDEX_W'(s / SLOTS_PER_WORD)) begin
					type_tab_q[s] <= cfg_data[(s % SLOTS_PER_WORD) * TYPE_W +: TYPE_W];
				end
			end
		end
	end

	// Input handshake: a frame is written to the queue on each transfer.
	assign in_ready = !queue_full;
	assign push     = in_valid && in_ready;

	erxf_front #(
		.TYPE_SLOTS (TYPE_SLOTS)
	) u_front (
		.dest_mac    (dest_mac),
		.src_mac     (src_mac),
		.type_field  (type_field),
		.frame_bytes (frame_bytes),
		.cfg         (cfg_q),
		.type_tab    (type_tab_q),
		.item        (front_item)
	);

	erxf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (front_item),
		.full      (queue_full),
		.pop       (queue_pop),
		.pop_item  (queue_item),
		.not_empty (queue_valid)
	);

	erxf_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.item_valid      (queue_valid),
		.item            (queue_item),
		.item_take       (queue_pop),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.verdict         (verdict),
		.handler_slot    (handler_slot),
		.addr_class      (addr_class),
		.rx_frames       (rx_frames),
		.rx_bytes        (rx_bytes),
		.bcast_frames    (bcast_frames),
		.mcast_frames    (mcast_frames),
		.ucast_frames    (ucast_frames),
		.filtered_frames (filtered_frames),
		.length_errors   (length_errors)
	);

endmodule
